/* hdl/lrd_pkg.sv */
// ----------------------------------------------------------------------------
// lrd_pkg
// Types, codes and the byte-wide CRC-32 update shared by the log record
// deframer.
// ----------------------------------------------------------------------------
package lrd_pkg;

  localparam int unsigned CfgIndexWidth = 2;
  localparam int unsigned CfgDataWidth  = 27;
  localparam int unsigned KeyMaxWidth   = 25;
  localparam int unsigned ValMaxWidth   = 27;
  localparam int unsigned OutDataWidth  = 80;

  localparam logic [KeyMaxWidth-1:0] KeyMaxReset = 25'(16 * 1024 * 1024);
  localparam logic [ValMaxWidth-1:0] ValMaxReset = 27'(64 * 1024 * 1024);
  localparam logic [31:0]            CrcPoly     = 32'hEDB8_8320;
  localparam logic [31:0]            CrcInit     = 32'hFFFF_FFFF;

  typedef enum logic [CfgIndexWidth-1:0] {
    REG_PUT_CODE       = 2'd0,
    REG_TOMBSTONE_CODE = 2'd1,
    REG_MAX_KEY_LENGTH = 2'd2,
    REG_MAX_VAL_LENGTH = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    KIND_KEY      = 2'd0,
    KIND_VALUE    = 2'd1,
    KIND_ACCEPTED = 2'd2,
    KIND_STOPPED  = 2'd3
  } out_kind_t;

  typedef enum logic [2:0] {
    ST_CLEAN_END    = 3'd0,
    ST_SHORT_HEADER = 3'd1,
    ST_BAD_TYPE     = 3'd2,
    ST_OVERSIZE     = 3'd3,
    ST_SHORT_KEY    = 3'd4,
    ST_SHORT_VALUE  = 3'd5,
    ST_SHORT_CRC    = 3'd6,
    ST_CRC_MISMATCH = 3'd7
  } status_t;

  typedef enum logic [4:0] {
    PH_HEADER = 5'b00001,
    PH_KEY    = 5'b00010,
    PH_VALUE  = 5'b00100,
    PH_CRC    = 5'b01000,
    PH_STOP   = 5'b10000
  } phase_t;

  // Reflected CRC-32, one byte folded in over eight bit steps.
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc_in,
                                             input logic [7:0]  data);
    logic [31:0] crc;
    crc = crc_in ^ {24'd0, data};
    for (int i = 0; i < 8; i++) begin
      crc = crc[0] ? ((crc >> 1) ^ CrcPoly) : (crc >> 1);
    end
    return crc;
  endfunction

endpackage

/* hdl/log_record_deframer.sv */
// ----------------------------------------------------------------------------
// log_record_deframer
// Splits a write-ahead log byte stream into records: type, key length,
// value length, key bytes, value bytes and a CRC-32 trailer.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Contents
//  -------  ---------  -------------------------------------------------------
//  s_*      in         one log byte (tdata), end of log (tlast)
//  m_*      out        key/value byte or verdict (tuser = kind), context fields
//  cfg_*    in         register writes: put code, tombstone code, length limits
//
// One input transfer is taken per cycle while the output keeps up. A byte
// is captured in an input register, parsed from there and its result, if
// any, lands in the output register. The CRC update and header length
// checks are the longest path. A stalled output holds the input register;
// the input side stalls only when both registers are full. rst clears all
// control state; after a stop the block drops every further byte until
// reset.
// ----------------------------------------------------------------------------
module log_record_deframer
  import lrd_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  // configuration
  input  logic                     cfg_we,
  input  logic [CfgIndexWidth-1:0] cfg_index,
  input  logic [CfgDataWidth-1:0]  cfg_data,
  // log byte stream
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [7:0]               s_tdata,   // [7:0] data_byte
  input  logic                     s_tlast,   // end_of_log
  // records out
  output logic                     m_tvalid,
  input  logic                     m_tready,
  // [7:0] payload_byte, [8] record_kind, [40:9] key_length,
  // [72:41] value_length, [75:73] status, [76] truncated, [79:77] zero
  output logic [OutDataWidth-1:0]  m_tdata,
  output logic [1:0]               m_tuser    // [1:0] kind
);

  // Configuration registers
  logic [7:0]             put_code;
  logic [7:0]             tomb_code;
  logic [KeyMaxWidth-1:0] max_key_len;
  logic [ValMaxWidth-1:0] max_val_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      put_code    <= 8'd0;
      tomb_code   <= 8'd1;
      max_key_len <= KeyMaxReset;
      max_val_len <= ValMaxReset;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PUT_CODE:       put_code    <= cfg_data[7:0];
        REG_TOMBSTONE_CODE: tomb_code   <= cfg_data[7:0];
        REG_MAX_KEY_LENGTH: max_key_len <= cfg_data[KeyMaxWidth-1:0];
        REG_MAX_VAL_LENGTH: max_val_len <= cfg_data[ValMaxWidth-1:0];
        default: ;
      endcase
    end
  end

  // Input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_eol;
  logic       proc_fire;

  assign proc_fire = in_valid && (!m_tvalid || m_tready);
  assign s_tready  = !in_valid || proc_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
      in_eol  <= s_tlast;
    end
  end

  // Parser state
  phase_t      phase,      phase_next;
  logic [3:0]  hdr_idx,    hdr_idx_next;
  logic [31:0] remaining,  remaining_next;
  logic [31:0] key_len,    key_len_next;
  logic [31:0] val_len,    val_len_next;
  logic [7:0]  type_code,  type_code_next;
  logic [31:0] run_crc,    run_crc_next;
  logic [31:0] stored_crc, stored_crc_next;

  // Result of the current byte
  logic        res_valid;
  out_kind_t   res_kind;
  logic [7:0]  res_byte;
  logic        res_ctx;
  status_t     res_status;
  logic        res_trunc;

  logic [1:0]  lane;
  logic [31:0] crc_base;

  always_comb begin
    phase_next      = phase;
    hdr_idx_next    = hdr_idx;
    remaining_next  = remaining;
    key_len_next    = key_len;
    val_len_next    = val_len;
    type_code_next  = type_code;
    run_crc_next    = run_crc;
    stored_crc_next = stored_crc;
    res_valid       = 1'b0;
    res_kind        = KIND_STOPPED;
    res_byte        = 8'd0;
    res_ctx         = 1'b0;
    res_status      = ST_CLEAN_END;
    res_trunc       = 1'b0;
    lane            = 2'(hdr_idx - 4'd1);
    crc_base        = run_crc;

    if (proc_fire && phase != PH_STOP) begin
      if (in_eol) begin
        res_valid  = 1'b1;
        res_kind   = KIND_STOPPED;
        res_trunc  = 1'b1;
        res_ctx    = 1'b1;
        phase_next = PH_STOP;
        unique case (phase)
          PH_HEADER: begin
            res_ctx = 1'b0;
            if (hdr_idx == 4'd0) begin
              res_status = ST_CLEAN_END;
              res_trunc  = 1'b0;
            end else begin
              res_status = ST_SHORT_HEADER;
            end
          end
          PH_KEY:   res_status = ST_SHORT_KEY;
          PH_VALUE: res_status = ST_SHORT_VALUE;
          default:  res_status = ST_SHORT_CRC;
        endcase
      end else begin
        unique case (phase)
          PH_HEADER: begin
            if (hdr_idx == 4'd0) begin
              crc_base       = CrcInit;
              key_len_next   = 32'd0;
              val_len_next   = 32'd0;
              type_code_next = in_byte;
            end else if (hdr_idx <= 4'd4) begin
              key_len_next[8*lane +: 8] = key_len[8*lane +: 8] | in_byte;
            end else begin
              val_len_next[8*lane +: 8] = val_len[8*lane +: 8] | in_byte;
            end
            run_crc_next = crc32_byte(crc_base, in_byte);
            hdr_idx_next = hdr_idx + 4'd1;
            if (hdr_idx == 4'd8) begin
              hdr_idx_next = 4'd0;
              res_ctx      = 1'b1;
              if (type_code_next != put_code && type_code_next != tomb_code) begin
                res_valid  = 1'b1;
                res_status = ST_BAD_TYPE;
                phase_next = PH_STOP;
              end else if (key_len_next > 32'(max_key_len)
                           || val_len_next > 32'(max_val_len)) begin
                res_valid  = 1'b1;
                res_status = ST_OVERSIZE;
                phase_next = PH_STOP;
              end else if (key_len_next != 32'd0) begin
                phase_next     = PH_KEY;
                remaining_next = key_len_next;
              end else if (val_len_next != 32'd0) begin
                phase_next     = PH_VALUE;
                remaining_next = val_len_next;
              end else begin
                phase_next      = PH_CRC;
                stored_crc_next = 32'd0;
              end
            end
          end
          PH_KEY, PH_VALUE: begin
            run_crc_next   = crc32_byte(run_crc, in_byte);
            res_valid      = 1'b1;
            res_kind       = (phase == PH_KEY) ? KIND_KEY : KIND_VALUE;
            res_byte       = in_byte;
            res_ctx        = 1'b1;
            remaining_next = remaining - 32'd1;
            if (remaining == 32'd1) begin
              if (phase == PH_KEY && val_len != 32'd0) begin
                phase_next     = PH_VALUE;
                remaining_next = val_len;
              end else begin
                phase_next      = PH_CRC;
                hdr_idx_next    = 4'd0;
                stored_crc_next = 32'd0;
              end
            end
          end
          PH_CRC: begin
            stored_crc_next[8*hdr_idx[1:0] +: 8] = stored_crc[8*hdr_idx[1:0] +: 8] | in_byte;
            hdr_idx_next = hdr_idx + 4'd1;
            if (hdr_idx == 4'd3) begin
              hdr_idx_next = 4'd0;
              res_valid    = 1'b1;
              res_ctx      = 1'b1;
              if ((run_crc ^ CrcInit) != stored_crc_next) begin
                res_status = ST_CRC_MISMATCH;
                phase_next = PH_STOP;
              end else begin
                res_kind     = KIND_ACCEPTED;
                phase_next   = PH_HEADER;
                run_crc_next = CrcInit;
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HEADER;
      hdr_idx    <= 4'd0;
      remaining  <= 32'd0;
      key_len    <= 32'd0;
      val_len    <= 32'd0;
      type_code  <= 8'd0;
      run_crc    <= CrcInit;
      stored_crc <= 32'd0;
    end else begin
      phase      <= phase_next;
      hdr_idx    <= hdr_idx_next;
      remaining  <= remaining_next;
      key_len    <= key_len_next;
      val_len    <= val_len_next;
      type_code  <= type_code_next;
      run_crc    <= run_crc_next;
      stored_crc <= stored_crc_next;
    end
  end

  // Output register
  logic rec_kind;

  // A type matching both codes counts as a put.
  assign rec_kind = (type_code_next == tomb_code) && (type_code_next != put_code);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (proc_fire && res_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_fire && res_valid) begin
      m_tuser <= res_kind;
      m_tdata <= {3'd0,
                  res_trunc,
                  res_status,
                  res_ctx ? val_len_next : 32'd0,
                  res_ctx ? key_len_next : 32'd0,
                  res_ctx & rec_kind,
                  res_byte};
    end
  end

endmodule

/* tb/tb_log_record_deframer.sv */
// ----------------------------------------------------------------------------
// tb_log_record_deframer
// Self-checking bench for the log record deframer. Whole records are built
// here with their CRC-32 trailers and streamed in byte by byte. A parser
// kept in step with the block predicts every key byte, value byte and
// verdict. The run goes through reset defaults, swapped and equal type
// codes, zero and maximum length limits, and random idling on both stream
// sides. Reset is applied once, so the run ends with a single randomly
// chosen stop condition followed by bytes the block has to drop.
// ----------------------------------------------------------------------------
module tb_log_record_deframer;
  import lrd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WatchdogLimit = 5000;
  localparam int unsigned HoldAfter     = 300;
  localparam int unsigned HoldCycles    = 80;
  localparam int unsigned PrintCap      = 40;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } log_item_t;

  typedef struct packed {
    out_kind_t   kind;
    logic [7:0]  payload;
    logic        rk;
    logic [31:0] klen;
    logic [31:0] vlen;
    status_t     status;
    logic        trunc;
  } deframed_t;

  // One directed record: type byte, lengths, fill byte for key and value,
  // and an optional hand-written verdict.
  typedef struct packed {
    logic [7:0] rtype;
    logic [7:0] klen;
    logic [7:0] vlen;
    logic [7:0] fill;
    logic       typed;
    logic       want_rk;
  } dir_row_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_we = 1'b0;
  logic [CfgIndexWidth-1:0] cfg_index = REG_PUT_CODE;
  logic [CfgDataWidth-1:0]  cfg_data = '0;
  logic                     s_tvalid = 1'b0;
  logic                     s_tready;
  logic [7:0]               s_tdata = '0;
  logic                     s_tlast = 1'b0;
  logic                     m_tvalid;
  logic                     m_tready = 1'b0;
  logic [OutDataWidth-1:0]  m_tdata;
  logic [1:0]               m_tuser;

  log_record_deframer u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  always #10 clk = ~clk;

  dir_row_t dir_rows [0:3] = '{
    '{8'h00, 8'd0, 8'd0, 8'h00, 1'b1, 1'b0},
    '{8'h01, 8'd1, 8'd0, 8'hFF, 1'b1, 1'b1},
    '{8'h00, 8'd0, 8'd1, 8'h00, 1'b1, 1'b0},
    '{8'h01, 8'd2, 8'd3, 8'h5A, 1'b0, 1'b0}
  };

  log_item_t   log_bytes_q [$];
  deframed_t   awaited_outputs [$];
  logic [7:0]  frame_buf [$];
  int unsigned queued_cnt = 0;
  int unsigned sent_cnt = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned err_cnt = 0;
  int unsigned got_cnt = 0;
  int unsigned records_ok = 0;
  int unsigned tombstones_ok = 0;
  int unsigned key_bytes = 0;
  int unsigned value_bytes = 0;
  int unsigned dropped_after_stop = 0;
  status_t     final_status = ST_CLEAN_END;

  // Parser state and its copy of the registers.
  phase_t      pmode;
  int unsigned hdr_pos;
  logic [31:0] left_cnt;
  logic [31:0] key_len;
  logic [31:0] val_len;
  logic [7:0]  rec_type;
  logic [31:0] crc_acc;
  logic [31:0] crc_trailer;
  bit          halted;
  logic [7:0]  cfg_put;
  logic [7:0]  cfg_tomb;
  logic [KeyMaxWidth-1:0] cfg_kmax;
  logic [ValMaxWidth-1:0] cfg_vmax;

  // Reflected CRC-32, one input bit per step.
  function automatic logic [31:0] crc_next(logic [31:0] crc, logic [7:0] b);
    logic [31:0] r;
    logic        fb;
    int          i;
    r = crc;
    for (i = 0; i < 8; i++) begin
      fb = r[0] ^ b[i];
      r = {1'b0, r[31:1]} ^ (fb ? CrcPoly : 32'd0);
    end
    return r;
  endfunction

  function automatic void reset_parser();
    cfg_put     = 8'd0;
    cfg_tomb    = 8'd1;
    cfg_kmax    = KeyMaxReset;
    cfg_vmax    = ValMaxReset;
    pmode       = PH_HEADER;
    hdr_pos     = 0;
    left_cnt    = '0;
    key_len     = '0;
    val_len     = '0;
    rec_type    = '0;
    crc_acc     = CrcInit;
    crc_trailer = '0;
    halted      = 1'b0;
  endfunction

  function automatic void emit_out(out_kind_t kind, logic [7:0] payload, bit ctx,
                                   status_t st, bit trunc);
    deframed_t o;
    o.kind    = kind;
    o.payload = payload;
    o.rk      = ctx && (rec_type == cfg_tomb) && (rec_type != cfg_put);
    o.klen    = ctx ? key_len : 32'd0;
    o.vlen    = ctx ? val_len : 32'd0;
    o.status  = st;
    o.trunc   = trunc;
    awaited_outputs.insert(awaited_outputs.size(), o);
  endfunction

  function automatic void stop_with(bit ctx, status_t st, bit trunc);
    emit_out(KIND_STOPPED, 8'h00, ctx, st, trunc);
    pmode  = PH_STOP;
    halted = 1'b1;
  endfunction

  // Advances the parser by one log byte and queues what the block must emit.
  function automatic void parse_log_byte(logic [7:0] b, bit eol);
    if (halted || pmode == PH_STOP) return;
    if (eol) begin
      case (pmode)
        PH_HEADER: begin
          if (hdr_pos == 0) stop_with(1'b0, ST_CLEAN_END, 1'b0);
          else stop_with(1'b0, ST_SHORT_HEADER, 1'b1);
        end
        PH_KEY:   stop_with(1'b1, ST_SHORT_KEY, 1'b1);
        PH_VALUE: stop_with(1'b1, ST_SHORT_VALUE, 1'b1);
        default:  stop_with(1'b1, ST_SHORT_CRC, 1'b1);
      endcase
      return;
    end
    case (pmode)
      PH_HEADER: begin
        if (hdr_pos == 0) begin
          crc_acc  = CrcInit;
          key_len  = '0;
          val_len  = '0;
          rec_type = b;
        end else if (hdr_pos <= 4) begin
          key_len[8*(hdr_pos-1) +: 8] = b;
        end else begin
          val_len[8*(hdr_pos-5) +: 8] = b;
        end
        crc_acc = crc_next(crc_acc, b);
        hdr_pos++;
        if (hdr_pos == 9) begin
          hdr_pos = 0;
          // The type is judged only once the whole header is in.
          if (rec_type != cfg_put && rec_type != cfg_tomb) begin
            stop_with(1'b1, ST_BAD_TYPE, 1'b0);
          end else if (key_len > cfg_kmax || val_len > cfg_vmax) begin
            stop_with(1'b1, ST_OVERSIZE, 1'b0);
          end else if (key_len != 0) begin
            pmode    = PH_KEY;
            left_cnt = key_len;
          end else if (val_len != 0) begin
            pmode    = PH_VALUE;
            left_cnt = val_len;
          end else begin
            pmode       = PH_CRC;
            crc_trailer = '0;
          end
        end
      end
      PH_KEY, PH_VALUE: begin
        crc_acc = crc_next(crc_acc, b);
        emit_out((pmode == PH_KEY) ? KIND_KEY : KIND_VALUE, b, 1'b1, ST_CLEAN_END, 1'b0);
        left_cnt--;
        if (left_cnt == 0) begin
          if (pmode == PH_KEY && val_len != 0) begin
            pmode    = PH_VALUE;
            left_cnt = val_len;
          end else begin
            pmode       = PH_CRC;
            hdr_pos     = 0;
            crc_trailer = '0;
          end
        end
      end
      default: begin
        crc_trailer[8*hdr_pos +: 8] = b;
        hdr_pos++;
        if (hdr_pos == 4) begin
          hdr_pos = 0;
          if (~crc_acc != crc_trailer) begin
            stop_with(1'b1, ST_CRC_MISMATCH, 1'b0);
          end else begin
            emit_out(KIND_ACCEPTED, 8'h00, 1'b1, ST_CLEAN_END, 1'b0);
            pmode   = PH_HEADER;
            crc_acc = CrcInit;
          end
        end
      end
    endcase
  endfunction

  function automatic void send_item(logic [7:0] b, bit eol);
    log_item_t item;
    item.data = b;
    item.last = eol;
    log_bytes_q.insert(log_bytes_q.size(), item);
    queued_cnt++;
    parse_log_byte(b, eol);
  endfunction

  // Builds one record into frame_buf; with hdr_only only the nine header bytes.
  function automatic void build_record(logic [7:0] rtype, logic [31:0] kl, logic [31:0] vl,
                                       bit rand_fill, logic [7:0] fill, bit hdr_only);
    logic [31:0] crc;
    int unsigned i;
    frame_buf.delete();
    frame_buf.insert(frame_buf.size(), rtype);
    for (i = 0; i < 4; i++) frame_buf.insert(frame_buf.size(), kl[8*i +: 8]);
    for (i = 0; i < 4; i++) frame_buf.insert(frame_buf.size(), vl[8*i +: 8]);
    if (hdr_only) return;
    for (i = 0; i < kl + vl; i++)
      frame_buf.insert(frame_buf.size(), rand_fill ? 8'($urandom) : fill);
    crc = CrcInit;
    foreach (frame_buf[j]) crc = crc_next(crc, frame_buf[j]);
    crc = ~crc;
    for (i = 0; i < 4; i++) frame_buf.insert(frame_buf.size(), crc[8*i +: 8]);
  endfunction

  function automatic void send_frame(int unsigned count);
    int unsigned i;
    for (i = 0; i < count && i < frame_buf.size(); i++) send_item(frame_buf[i], 1'b0);
  endfunction

  // Well-formed records with random type, lengths within the limits, and data.
  function automatic void random_records(int unsigned target, int unsigned kl_hi,
                                         int unsigned vl_hi);
    int unsigned done_items;
    int unsigned kl_cap;
    int unsigned vl_cap;
    logic [7:0]  t;
    done_items = 0;
    kl_cap = (cfg_kmax < kl_hi) ? cfg_kmax : kl_hi;
    vl_cap = (cfg_vmax < vl_hi) ? cfg_vmax : vl_hi;
    while (done_items < target) begin
      t = $urandom_range(1) ? cfg_put : cfg_tomb;
      build_record(t, $urandom_range(kl_cap), $urandom_range(vl_cap), 1'b1, 8'h00, 1'b0);
      send_frame(frame_buf.size());
      done_items += frame_buf.size();
    end
  endfunction

  // Ends the stream with one stop condition, then offers bytes that must be dropped.
  function automatic void end_stream();
    status_t     pick;
    int unsigned kl;
    int unsigned vl;
    int unsigned cut;
    int unsigned n;
    bit          need_eol;
    logic [7:0]  t;
    pick     = status_t'($urandom_range(7));
    kl       = $urandom_range(6, 1);
    vl       = $urandom_range(6, 1);
    need_eol = 1'b1;
    build_record($urandom_range(1) ? cfg_put : cfg_tomb, kl, vl, 1'b1, 8'h00, 1'b0);
    cut = frame_buf.size();
    case (pick)
      ST_CLEAN_END:    cut = 0;
      ST_SHORT_HEADER: cut = $urandom_range(8, 1);
      ST_BAD_TYPE: begin
        do t = 8'($urandom); while (t == cfg_put || t == cfg_tomb);
        build_record(t, kl, vl, 1'b1, 8'h00, 1'b0);
        cut      = frame_buf.size();
        need_eol = 1'b0;
      end
      ST_OVERSIZE: begin
        if ($urandom_range(1))
          build_record(cfg_put, $urandom_range(32'hFFFF_FFFF, {7'd0, cfg_kmax} + 32'd1),
                       vl, 1'b1, 8'h00, 1'b1);
        else
          build_record(cfg_tomb, kl,
                       $urandom_range(32'hFFFF_FFFF, {5'd0, cfg_vmax} + 32'd1),
                       1'b1, 8'h00, 1'b1);
        cut      = frame_buf.size();
        need_eol = 1'b0;
      end
      ST_SHORT_KEY:   cut = 9 + $urandom_range(kl - 1);
      ST_SHORT_VALUE: cut = 9 + kl + $urandom_range(vl - 1);
      ST_SHORT_CRC:   cut = 9 + kl + vl + $urandom_range(3);
      default: begin
        frame_buf[frame_buf.size() - 1 - $urandom_range(3)] ^= 8'($urandom_range(255, 1));
        need_eol = 1'b0;
      end
    endcase
    send_frame(cut);
    if (need_eol) send_item(8'($urandom), 1'b1);
    for (n = 0; n < 20; n++) send_item(8'($urandom), 1'($urandom));
  endfunction

  task automatic report_mismatch(string msg);
    err_cnt++;
    if (err_cnt <= PrintCap) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  task automatic check_field(string name, int unsigned idx, logic [31:0] got,
                             logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("output %0d %s got 0x%0h want 0x%0h", idx, name, got, want));
  endtask

  // Writes all four registers, one per cycle, from a rising edge.
  task automatic set_config(logic [7:0] put_c, logic [7:0] tomb_c,
                            logic [KeyMaxWidth-1:0] kmax, logic [ValMaxWidth-1:0] vmax);
    cfg_reg_t idx;
    logic [CfgDataWidth-1:0] val;
    idx = idx.first();
    repeat (4) begin
      // Bits above each register's width carry junk that must be dropped.
      case (idx)
        REG_PUT_CODE:       val = {19'($urandom), put_c};
        REG_TOMBSTONE_CODE: val = {19'($urandom), tomb_c};
        REG_MAX_KEY_LENGTH: val = {2'($urandom), kmax};
        default:            val = vmax;
      endcase
      cfg_we    <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= val;
      @(posedge clk);
      idx = idx.next();
    end
    cfg_we   <= 1'b0;
    cfg_put  = put_c;
    cfg_tomb = tomb_c;
    cfg_kmax = kmax;
    cfg_vmax = vmax;
  endtask

  // Returns on a rising edge once every byte is taken and every output seen.
  task automatic drain();
    do @(negedge clk); while (sent_cnt != queued_cnt || awaited_outputs.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // Log byte sender.
  always @(posedge clk) begin : sender
    log_item_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) sent_cnt++;
      if (!s_tvalid || s_tready) begin
        if (log_bytes_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = log_bytes_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= nxt.data;
          s_tlast  <= nxt.last;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Output receiver and checker. Once, it holds off long enough for the
  // block to fill and stall its input.
  always @(posedge clk) begin : receiver
    deframed_t   got;
    deframed_t   want;
    int unsigned hold_left;
    bit          hold_done;
    if (rst) begin
      m_tready  <= 1'b0;
      hold_left = 0;
      hold_done = 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.kind    = out_kind_t'(m_tuser);
        got.payload = m_tdata[7:0];
        got.rk      = m_tdata[8];
        got.klen    = m_tdata[40:9];
        got.vlen    = m_tdata[72:41];
        got.status  = status_t'(m_tdata[75:73]);
        got.trunc   = m_tdata[76];
        if (awaited_outputs.size() == 0) begin
          report_mismatch($sformatf("output %0d of kind %s with nothing expected",
                                    got_cnt, got.kind.name()));
        end else begin
          want = awaited_outputs.pop_front();
          check_field("kind", got_cnt, got.kind, want.kind);
          check_field("payload_byte", got_cnt, got.payload, want.payload);
          check_field("record_kind", got_cnt, got.rk, want.rk);
          check_field("key_length", got_cnt, got.klen, want.klen);
          check_field("value_length", got_cnt, got.vlen, want.vlen);
          check_field("status", got_cnt, got.status, want.status);
          check_field("truncated", got_cnt, got.trunc, want.trunc);
        end
        case (got.kind)
          KIND_KEY:      key_bytes++;
          KIND_VALUE:    value_bytes++;
          KIND_ACCEPTED: begin
            records_ok++;
            if (got.rk) tombstones_ok++;
          end
          default:       final_status = got.status;
        endcase
        got_cnt++;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (!hold_done && got_cnt >= HoldAfter) begin
        hold_left = HoldCycles;
        hold_done = 1'b1;
        m_tready  <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Ends the run if neither side completes a transfer for too long.
  always @(posedge clk) begin : watchdog
    int unsigned quiet;
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
    else quiet++;
    if (quiet == WatchdogLimit) begin
      $display("[%0t] no transfer for %0d cycles", $realtime, WatchdogLimit);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin : main_seq
    int unsigned r;
    logic [7:0]  code;
    reset_parser();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed records under the reset register values.
    @(negedge clk);
    send_idle_pct = 25;
    recv_idle_pct = 66;
    for (r = 0; r < 4; r++) begin
      build_record(dir_rows[r].rtype, dir_rows[r].klen, dir_rows[r].vlen, 1'b0,
                   dir_rows[r].fill, 1'b0);
      send_frame(frame_buf.size());
      if (dir_rows[r].typed)
        awaited_outputs[awaited_outputs.size()-1] = '{KIND_ACCEPTED, 8'h00,
          dir_rows[r].want_rk, 32'(dir_rows[r].klen), 32'(dir_rows[r].vlen),
          ST_CLEAN_END, 1'b0};
    end
    drain();

    // Extreme type codes swapped from their reset roles, reset length limits.
    set_config(8'hFF, 8'h00, KeyMaxReset, ValMaxReset);
    @(negedge clk);
    random_records(600, 6, 12);
    drain();

    // Put and tombstone share one code, so nothing is a tombstone; no keys.
    code = 8'($urandom);
    set_config(code, code, '0, 27'd5);
    @(negedge clk);
    send_idle_pct = 66;
    recv_idle_pct = 25;
    random_records(400, 4, 8);
    drain();

    set_config(8'($urandom), 8'($urandom), 25'd3, '0);
    @(negedge clk);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_records(400, 6, 4);
    drain();

    set_config(8'($urandom), 8'($urandom), '1, '1);
    @(negedge clk);
    random_records(600, 8, 8);
    end_stream();
    drain();
    repeat (10) @(posedge clk);

    if (awaited_outputs.size() != 0)
      report_mismatch($sformatf("%0d outputs never arrived", awaited_outputs.size()));
    $display("Checked %0d outputs: %0d records (%0d tombstones), %0d key and %0d value bytes,",
             got_cnt, records_ok, tombstones_ok, key_bytes, value_bytes);
    $display("over %0d log bytes and four register settings; stream stopped with %s.",
             queued_cnt, final_status.name());
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
